// File: hdl/tsn_pkg.sv
`timescale 1ns / 1ps

package tsn_pkg;

    // Defaults for the top-level parameters
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int BACKOFF_MAX_DEF = 1024;

    // Result queue between the message engine and the output stage
    localparam int FIFO_DEPTH = 4;

    // Input event codes
    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_DISCOVERY  = 3'd1,
        KIND_PULSE      = 3'd2,
        KIND_REQUEST    = 3'd3,
        KIND_ACK        = 3'd4,
        KIND_ORIG_DISC  = 3'd5,
        KIND_ORIG_PULSE = 3'd6
    } t_in_kind;

    // Result codes
    typedef enum logic [2:0] {
        OUT_DISCOVERY = 3'd0,
        OUT_PULSE     = 3'd1,
        OUT_REQUEST   = 3'd2,
        OUT_ACK       = 3'd3,
        OUT_REPORT    = 3'd4
    } t_out_kind;

    // One result beat
    typedef struct packed {
        t_out_kind   kind;
        logic [15:0] sender;
        logic [15:0] dest;
        logic [15:0] bcast;
        logic [15:0] level;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] offset;
        logic [31:0] local_time;
        logic        last;
    } t_beat;

    // Up to two beats written into the queue in one cycle; wr1 implies wr0
    typedef struct packed {
        logic  wr0;
        logic  wr1;
        t_beat beat0;
        t_beat beat1;
    } t_push;

    // Queue status toward the engine and the output stage
    typedef struct packed {
        logic empty;
        logic room2;
    } t_fifo_stat;

endpackage

// File: hdl/tsn_engine.sv
`timescale 1ns / 1ps

module tsn_engine
    import tsn_pkg::*;
#(
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int BACKOFF_MAX = BACKOFF_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_sender_id,
    input  logic [15:0] i_dest_id,
    input  logic [15:0] i_bcast_id,
    input  logic [15:0] i_tree_level,
    input  logic [31:0] i_stamp_one,
    input  logic [31:0] i_stamp_two,
    input  logic [31:0] i_stamp_three,
    input  logic [10:0] i_backoff_ticks,
    input  t_fifo_stat  i_fifo_stat,
    output t_push       o_push
);

    localparam int EXT = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
    localparam int WW  = $clog2(BACKOFF_MAX + 1);
    localparam int BW  = (WW > 11) ? WW : 11;

    logic [TIME_WIDTH-1:0] r_clock, n_clock;
    logic [15:0]           r_own_id;
    logic [15:0]           r_parent, n_parent;
    logic [15:0]           r_level, n_level;
    logic [15:0]           r_round, n_round;
    logic [15:0]           r_pulse_from, n_pulse_from;
    logic [WW-1:0]         r_pulse_wait, n_pulse_wait;
    logic [WW-1:0]         r_heard_wait, n_heard_wait;

    logic                  accept;
    logic [TIME_WIDTH-1:0] clock_inc;
    logic [EXT-1:0]        cur_ext;
    logic [EXT-1:0]        inc_ext;
    logic [EXT-1:0]        nxt_ext;
    logic [31:0]           t4;
    logic [31:0]           d_fwd;
    logic [31:0]           d_back;
    logic [32:0]           d_diff;
    logic [32:0]           d_rnd;
    logic signed [31:0]    offset;
    logic signed [EXT-1:0] off_ext;
    logic [BW-1:0]         bo_raw;
    logic [BW-1:0]         bo_sat;
    logic [WW-1:0]         bo;
    logic                  pulse_fire;
    logic                  heard_fire;
    logic                  wr0, wr1;
    t_beat                 beat0, beat1, req;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = i_fifo_stat.room2;

    assign clock_inc = r_clock + TIME_WIDTH'(1);
    assign cur_ext   = EXT'(r_clock);
    assign inc_ext   = EXT'(clock_inc);
    assign t4        = cur_ext[31:0];

    // Two-way offset: ((t2 - t1) - (t4 - t3)) / 2, signed, toward zero
    assign d_fwd   = i_stamp_two - i_stamp_one;
    assign d_back  = t4 - i_stamp_three;
    assign d_diff  = {d_fwd[31], d_fwd} - {d_back[31], d_back};
    assign d_rnd   = d_diff + {32'd0, d_diff[32]};
    assign offset  = d_rnd[32:1];
    assign off_ext = EXT'(offset);

    // Backoff: zero acts as one, saturate at the maximum
    assign bo_raw = BW'(i_backoff_ticks);
    assign bo_sat = (bo_raw == '0) ? BW'(1) :
                    (bo_raw > BW'(BACKOFF_MAX)) ? BW'(BACKOFF_MAX) : bo_raw;
    assign bo     = bo_sat[WW-1:0];

    assign pulse_fire = (r_pulse_wait == WW'(1)) && (r_pulse_from == r_parent);
    assign heard_fire = (r_heard_wait == WW'(1));

    always_comb begin
        n_clock      = r_clock;
        n_parent     = r_parent;
        n_level      = r_level;
        n_round      = r_round;
        n_pulse_from = r_pulse_from;
        n_pulse_wait = r_pulse_wait;
        n_heard_wait = r_heard_wait;
        wr0          = 1'b0;
        wr1          = 1'b0;
        beat0        = '0;
        beat0.sender = r_own_id;
        req          = beat0;
        req.kind     = OUT_REQUEST;
        req.dest     = r_parent;
        req.t1       = inc_ext[31:0];

        unique case (i_kind)
            KIND_TICK: begin
                n_clock = clock_inc;
                if (r_pulse_wait != '0) begin
                    n_pulse_wait = r_pulse_wait - WW'(1);
                end
                if (r_heard_wait != '0) begin
                    n_heard_wait = r_heard_wait - WW'(1);
                end
                wr0   = pulse_fire || heard_fire;
                wr1   = pulse_fire && heard_fire;
                beat0 = req;
            end
            KIND_DISCOVERY: begin
                if (i_bcast_id != r_round) begin
                    n_round     = i_bcast_id;
                    n_parent    = i_sender_id;
                    n_level     = i_tree_level + 16'd1;
                    wr0         = 1'b1;
                    beat0.kind  = OUT_DISCOVERY;
                    beat0.bcast = i_bcast_id;
                    beat0.level = i_tree_level + 16'd1;
                end
            end
            KIND_PULSE: begin
                n_pulse_from = i_sender_id;
                if (i_sender_id == r_parent) begin
                    n_pulse_wait = bo;
                end
            end
            KIND_REQUEST: begin
                if (i_dest_id != r_own_id) begin
                    if (i_sender_id == r_parent) begin
                        n_heard_wait = bo;
                    end
                end else begin
                    wr0        = 1'b1;
                    beat0.kind = OUT_ACK;
                    beat0.dest = i_sender_id;
                    beat0.t1   = i_stamp_one;
                    beat0.t2   = t4;
                    beat0.t3   = t4;
                end
            end
            KIND_ACK: begin
                if (i_dest_id == r_own_id) begin
                    n_clock      = r_clock + off_ext[TIME_WIDTH-1:0];
                    wr0          = 1'b1;
                    beat0.kind   = OUT_REPORT;
                    beat0.offset = offset;
                end
            end
            KIND_ORIG_DISC: begin
                n_round     = r_round + 16'd1;
                wr0         = 1'b1;
                beat0.kind  = OUT_DISCOVERY;
                beat0.bcast = r_round + 16'd1;
            end
            KIND_ORIG_PULSE: begin
                wr0        = 1'b1;
                beat0.kind = OUT_PULSE;
            end
            default: begin
            end
        endcase

        // Every beat reports the clock after the step; mark the final one
        nxt_ext          = EXT'(n_clock);
        beat1            = req;
        beat0.local_time = nxt_ext[31:0];
        beat1.local_time = nxt_ext[31:0];
        beat0.last       = !wr1;
        beat1.last       = 1'b1;
    end

    assign o_push.wr0   = accept && wr0;
    assign o_push.wr1   = accept && wr1;
    assign o_push.beat0 = beat0;
    assign o_push.beat1 = beat1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock      <= '0;
            r_own_id     <= '0;
            r_parent     <= '0;
            r_level      <= '0;
            r_round      <= '0;
            r_pulse_from <= '0;
            r_pulse_wait <= '0;
            r_heard_wait <= '0;
        end else begin
            if (i_cfg_we) begin
                r_own_id <= i_cfg_data;
            end
            if (accept) begin
                r_clock      <= n_clock;
                r_parent     <= n_parent;
                r_level      <= n_level;
                r_round      <= n_round;
                r_pulse_from <= n_pulse_from;
                r_pulse_wait <= n_pulse_wait;
                r_heard_wait <= n_heard_wait;
            end
        end
    end

endmodule

// File: hdl/tsn_fifo.sv
`timescale 1ns / 1ps

module tsn_fifo
    import tsn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    input  logic       i_pop,
    output t_beat      o_head,
    output t_fifo_stat o_stat
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_beat         r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] wptr1;

    assign wptr1         = r_wptr + AW'(1);
    assign o_head        = r_mem[r_rptr];
    assign o_stat.empty  = (r_count == '0);
    assign o_stat.room2  = (r_count <= CW'(FIFO_DEPTH - 2));

    always_comb begin
        n_wptr  = r_wptr + AW'(i_push.wr0) + AW'(i_push.wr1);
        n_rptr  = r_rptr + AW'(i_pop);
        n_count = r_count + CW'(i_push.wr0) + CW'(i_push.wr1) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.wr0) begin
            r_mem[r_wptr] <= i_push.beat0;
        end
        if (i_push.wr1) begin
            r_mem[wptr1] <= i_push.beat1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// File: hdl/tsn_out.sv
`timescale 1ns / 1ps

module tsn_out
    import tsn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_beat      i_head,
    input  t_fifo_stat i_stat,
    output logic       o_pop,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_beat      o_beat
);

    logic  r_valid;
    t_beat r_beat;

    // Refill when the register is empty or its beat leaves this cycle
    assign o_pop       = !i_stat.empty && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_beat      = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_beat <= i_head;
        end
    end

endmodule

// File: hdl/tree_time_sync_node.sv
`timescale 1ns / 1ps
// Path: an accepted input beat is written into the result queue and then loaded into the
//   registered output stage; a second beat from the same tick leaves the queue after the first.
// Throughput: one input beat per cycle while the result queue has room for two
//   beats; the output stage drains one result beat per cycle while the consumer is ready.
// Reset: synchronous, active low; clears clock, tree state, timers, own id,
//   the result queue and the output valid.

module tree_time_sync_node
    import tsn_pkg::*;
#(
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int BACKOFF_MAX = BACKOFF_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: own node id
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    // event channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_sender_id,
    input  logic [15:0] i_dest_id,
    input  logic [15:0] i_bcast_id,
    input  logic [15:0] i_tree_level,
    input  logic [31:0] i_stamp_one,
    input  logic [31:0] i_stamp_two,
    input  logic [31:0] i_stamp_three,
    input  logic [10:0] i_backoff_ticks,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_out_kind,
    output logic [15:0] o_out_sender,
    output logic [15:0] o_out_dest,
    output logic [15:0] o_out_bcast,
    output logic [15:0] o_out_level,
    output logic [31:0] o_out_t1,
    output logic [31:0] o_out_t2,
    output logic [31:0] o_out_t3,
    output logic signed [31:0] o_clock_offset,
    output logic [31:0] o_local_time,
    output logic        o_last_of_run
);

    t_push      push;
    t_fifo_stat fifo_stat;
    t_beat      head;
    t_beat      beat;
    logic       pop;

    // Engine: takes one event per cycle while the queue has room for two beats, updates
    // the sync state and builds up to two result beats (a tick may expire both backoff timers).
    tsn_engine #(
        .TIME_WIDTH  (TIME_WIDTH),
        .BACKOFF_MAX (BACKOFF_MAX)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_sender_id     (i_sender_id),
        .i_dest_id       (i_dest_id),
        .i_bcast_id      (i_bcast_id),
        .i_tree_level    (i_tree_level),
        .i_stamp_one     (i_stamp_one),
        .i_stamp_two     (i_stamp_two),
        .i_stamp_three   (i_stamp_three),
        .i_backoff_ticks (i_backoff_ticks),
        .i_fifo_stat     (fifo_stat),
        .o_push          (push)
    );

    // Short result queue; decouples engine from output back-pressure
    tsn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (fifo_stat)
    );

    // Registered output stage
    tsn_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_stat      (fifo_stat),
        .o_pop       (pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_beat      (beat)
    );

    assign o_out_kind     = beat.kind;
    assign o_out_sender   = beat.sender;
    assign o_out_dest     = beat.dest;
    assign o_out_bcast    = beat.bcast;
    assign o_out_level    = beat.level;
    assign o_out_t1       = beat.t1;
    assign o_out_t2       = beat.t2;
    assign o_out_t3       = beat.t3;
    assign o_clock_offset = beat.offset;
    assign o_local_time   = beat.local_time;
    assign o_last_of_run  = beat.last;

endmodule

// File: hdl/tsn_checker.sv
`timescale 1ns / 1ps

module tsn_checker
    import tsn_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_out_kind,
    input logic [15:0] o_out_dest,
    input logic [31:0] o_out_t1,
    input logic [31:0] o_out_t2,
    input logic [31:0] o_clock_offset,
    input logic [31:0] o_local_time
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_kind) && $stable(o_local_time))
        else $error("result beat changed while stalled");

    // Reset empties the output stage
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Discovery and pulse beats carry no addressing or stamps
    a_bcast_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_kind == OUT_DISCOVERY || o_out_kind == OUT_PULSE) |->
            o_out_dest == '0 && o_out_t1 == '0 && o_out_t2 == '0)
        else $error("broadcast beat carries stray fields");

    // Only a correction report carries an offset
    a_offset_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind != OUT_REPORT |-> o_clock_offset == '0)
        else $error("offset on non-report beat");

endmodule

bind tree_time_sync_node tsn_checker u_tsn_checker (.*);
